@@ rtl/core/jsc_pkg.sv @@
package jsc_pkg;

   // Stick state machine, one-hot
   typedef enum logic [6:0] {
      ST_START = 7'b0000001,
      ST_BTN   = 7'b0000010,
      ST_NEUT  = 7'b0000100,
      ST_UP    = 7'b0001000,
      ST_DOWN  = 7'b0010000,
      ST_LEFT  = 7'b0100000,
      ST_RIGHT = 7'b1000000
   } stick_type;

   // Codes of the stick state as shown on the result word
   localparam logic [2:0] CODE_START = 3'd0;
   localparam logic [2:0] CODE_BTN   = 3'd1;
   localparam logic [2:0] CODE_NEUT  = 3'd2;
   localparam logic [2:0] CODE_UP    = 3'd3;
   localparam logic [2:0] CODE_DOWN  = 3'd4;
   localparam logic [2:0] CODE_LEFT  = 3'd5;
   localparam logic [2:0] CODE_RIGHT = 3'd6;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_CENTER    = 2'd0,
      CSR_THRESHOLD = 2'd1
   } csr_index_type;

   // Item kinds
   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_STICK = 1'b1;

   // Indicator patterns
   localparam logic [3:0] IND_ALL   = 4'hF;
   localparam logic [3:0] IND_UP    = 4'h1;
   localparam logic [3:0] IND_DOWN  = 4'h2;
   localparam logic [3:0] IND_LEFT  = 4'h4;
   localparam logic [3:0] IND_RIGHT = 4'h8;

   localparam logic [1:0] SPEED_MAX   = 2'd3;
   localparam logic [1:0] SPEED_MIN   = 2'd0;
   localparam logic [1:0] SPEED_RESET = 2'd1;

   // Everything a result word carries
   typedef struct packed {
      logic [3:0] coil;
      logic [3:0] led;
      logic [1:0] speed;
      logic       halt;
      logic       fwd;
      stick_type  state;
   } status_type;

   // Half-step coil sequence
   function automatic logic [3:0] coil_lookup(input logic [2:0] idx);
      logic [3:0] pat;
      case (idx)
         3'd0:    pat = 4'h8;
         3'd1:    pat = 4'hC;
         3'd2:    pat = 4'h4;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h2;
         3'd5:    pat = 4'h3;
         3'd6:    pat = 4'h1;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

   function automatic logic [2:0] stick_code(input stick_type st);
      logic [2:0] code;
      case (st)
         ST_BTN:   code = CODE_BTN;
         ST_NEUT:  code = CODE_NEUT;
         ST_UP:    code = CODE_UP;
         ST_DOWN:  code = CODE_DOWN;
         ST_LEFT:  code = CODE_LEFT;
         ST_RIGHT: code = CODE_RIGHT;
         default:  code = CODE_START;
      endcase
      return code;
   endfunction

endpackage

@@ rtl/core/jsc_classify.sv @@
module jsc_classify #(
   parameter int ADC_BITS = 10
) (
   input  logic [ADC_BITS-1:0] axis_x,
   input  logic [ADC_BITS-1:0] axis_y,
   input  logic                button_pressed,
   input  logic [ADC_BITS-1:0] center,
   input  logic [ADC_BITS-2:0] threshold,
   output jsc_pkg::stick_type  cls
);
   import jsc_pkg::*;

   logic [ADC_BITS:0]   dx;
   logic [ADC_BITS:0]   dy;
   logic [ADC_BITS-1:0] mag_x;
   logic [ADC_BITS-1:0] mag_y;
   logic [ADC_BITS-1:0] thr;

   // Signed deflection from center and its magnitude
   always_comb begin
      dx    = {1'b0, axis_x} - {1'b0, center};
      dy    = {1'b0, axis_y} - {1'b0, center};
      mag_x = dx[ADC_BITS] ? (~dx[ADC_BITS-1:0] + 1'b1) : dx[ADC_BITS-1:0];
      mag_y = dy[ADC_BITS] ? (~dy[ADC_BITS-1:0] + 1'b1) : dy[ADC_BITS-1:0];
      thr   = {1'b0, threshold};
   end

   // Button wins, then the dominant axis against the deadzone
   always_comb begin
      cls = ST_NEUT;
      if (button_pressed) begin
         cls = ST_BTN;
      end else if (mag_x > mag_y) begin
         if (mag_x >= thr) begin
            cls = dx[ADC_BITS] ? ST_DOWN : ST_UP;
         end
      end else begin
         if (mag_y >= thr) begin
            cls = dy[ADC_BITS] ? ST_LEFT : ST_RIGHT;
         end
      end
   end

endmodule

@@ rtl/core/jsc_core.sv @@
module jsc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                mode,
   input  jsc_pkg::stick_type  cls,
   output jsc_pkg::status_type status_in
);
   import jsc_pkg::*;

   stick_type  state_ff, state_in;
   logic [1:0] speed_ff, speed_in;
   logic       fwd_ff,   fwd_in;
   logic       halt_ff,  halt_in;
   logic [3:0] led_ff,   led_in;
   logic [2:0] phase_ff, phase_in;
   logic [1:0] wait_ff,  wait_in;
   logic [3:0] coil_ff,  coil_in;

   // Next state for the word in flight
   always_comb begin
      state_in = state_ff;
      speed_in = speed_ff;
      fwd_in   = fwd_ff;
      halt_in  = halt_ff;
      led_in   = led_ff;
      phase_in = phase_ff;
      wait_in  = wait_ff;
      coil_in  = coil_ff;
      if (mode == MODE_TICK) begin
         // prescaler and stepping
         if (!halt_ff) begin
            if (wait_ff != 2'd0) begin
               wait_in = wait_ff - 2'd1;
            end else begin
               wait_in  = SPEED_MAX - speed_ff;
               coil_in  = coil_lookup(phase_ff);
               phase_in = fwd_ff ? phase_ff + 3'd1 : phase_ff - 3'd1;
            end
         end
      end else begin
         // transition
         case (state_ff)
            ST_BTN, ST_UP, ST_DOWN: begin
               state_in = (cls == state_ff) ? state_ff : ST_NEUT;
            end
            ST_NEUT, ST_LEFT, ST_RIGHT: begin
               state_in = cls;
               if (cls == ST_UP && speed_ff != SPEED_MAX) begin
                  speed_in = speed_ff + 2'd1;
               end else if (cls == ST_DOWN && speed_ff != SPEED_MIN) begin
                  speed_in = speed_ff - 2'd1;
               end
            end
            default: begin
               state_in = ST_RIGHT;
            end
         endcase
         // actions in the new state
         case (state_in)
            ST_BTN: begin
               led_in  = IND_ALL;
               halt_in = 1'b1;
            end
            ST_NEUT: begin
               led_in  = fwd_ff ? IND_LEFT : IND_RIGHT;
               halt_in = 1'b0;
            end
            ST_UP: begin
               led_in = led_ff | IND_UP;
            end
            ST_DOWN: begin
               led_in = led_ff | IND_DOWN;
            end
            ST_LEFT: begin
               led_in = IND_LEFT;
               fwd_in = 1'b1;
            end
            default: begin
               led_in = IND_RIGHT;
               fwd_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         speed_ff <= SPEED_RESET;
         fwd_ff   <= 1'b0;
         halt_ff  <= 1'b0;
         led_ff   <= 4'h0;
         phase_ff <= 3'd0;
         wait_ff  <= 2'd0;
         coil_ff  <= 4'h0;
      end else if (fire) begin
         state_ff <= state_in;
         speed_ff <= speed_in;
         fwd_ff   <= fwd_in;
         halt_ff  <= halt_in;
         led_ff   <= led_in;
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         coil_ff  <= coil_in;
      end
   end

   always_comb begin
      status_in.coil  = coil_in;
      status_in.led   = led_in;
      status_in.speed = speed_in;
      status_in.halt  = halt_in;
      status_in.fwd   = fwd_in;
      status_in.state = state_in;
   end

endmodule

@@ rtl/core/joystick_stepper_controller.sv @@
// Channel | Direction | Handshake             | Word
// req     | in        | req_valid / req_ready | mode, axis_x, axis_y, button_pressed
// rsp     | out       | rsp_valid / rsp_ready | coil, leds, speed, halted, forward, state
// csr     | in        | csr_we                | csr_index, csr_data (no read-back)
//
// One word per cycle sustained while rsp_ready is high; a word is taken into the input
// register when accepted and its result is offered once the result register loads it.
// Synchronous active-high reset restores all state and both config registers.
// A stalled result holds while the input register still takes one more word;
// req_ready drops only when both registers are full and rsp_ready is low.
module joystick_stepper_controller #(
   parameter int ADC_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [ADC_BITS-1:0] req_axis_x,
   input  logic [ADC_BITS-1:0] req_axis_y,
   input  logic                req_button_pressed,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [3:0]          rsp_coil_pattern,
   output logic [3:0]          rsp_led_pattern,
   output logic [1:0]          rsp_speed_level,
   output logic                rsp_halted,
   output logic                rsp_moving_forward,
   output logic [2:0]          rsp_stick_state,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [ADC_BITS-1:0] csr_data
);
   import jsc_pkg::*;

   localparam logic [ADC_BITS-1:0] CenterReset = ADC_BITS'(1 << (ADC_BITS - 1));
   localparam logic [ADC_BITS-2:0] ThrReset    =
      (ADC_BITS-1)'((200 * (1 << ADC_BITS)) / 1024);

   logic                in_valid_ff;
   logic                in_mode_ff;
   logic [ADC_BITS-1:0] in_x_ff;
   logic [ADC_BITS-1:0] in_y_ff;
   logic                in_btn_ff;
   logic                out_valid_ff;
   status_type          out_ff;
   status_type          status_in;
   stick_type           cls;
   logic [ADC_BITS-1:0] center_ff;
   logic [ADC_BITS-2:0] thr_ff;
   logic                advance;
   logic                fire;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CenterReset;
         thr_ff    <= ThrReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER:    center_ff <= csr_data;
            CSR_THRESHOLD: thr_ff    <= csr_data[ADC_BITS-2:0];
            default:       ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff <= req_mode;
         in_x_ff    <= req_axis_x;
         in_y_ff    <= req_axis_y;
         in_btn_ff  <= req_button_pressed;
      end
   end

   jsc_classify #(
      .ADC_BITS(ADC_BITS)
   ) u_classify (
      .axis_x        (in_x_ff),
      .axis_y        (in_y_ff),
      .button_pressed(in_btn_ff),
      .center        (center_ff),
      .threshold     (thr_ff),
      .cls           (cls)
   );

   jsc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .mode     (in_mode_ff),
      .cls      (cls),
      .status_in(status_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= status_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_coil_pattern   = out_ff.coil;
   assign rsp_led_pattern    = out_ff.led;
   assign rsp_speed_level    = out_ff.speed;
   assign rsp_halted         = out_ff.halt;
   assign rsp_moving_forward = out_ff.fwd;
   assign rsp_stick_state    = stick_code(out_ff.state);

endmodule

@@ test/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import jsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_ITEMS = 113;
   localparam int MAX_REPORTS = 10;

   // Register indexes the block must ignore
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   // Half-step coil sequence, entry 0 in the low nibble
   localparam logic [31:0] HALF_STEP_SEQ = {4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8};

   typedef struct packed {
      logic [3:0] coil;
      logic [3:0] led;
      logic [1:0] speed;
      logic       halt;
      logic       fwd;
      logic [2:0] state;
   } motor_status_type;

   typedef struct {
      logic             mode;
      logic [9:0]       ax;
      logic [9:0]       ay;
      logic             btn;
      bit               known;
      motor_status_type want;
   } script_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_mode;
   logic [9:0] req_axis_x;
   logic [9:0] req_axis_y;
   logic       req_button_pressed;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [3:0] rsp_coil_pattern;
   logic [3:0] rsp_led_pattern;
   logic [1:0] rsp_speed_level;
   logic       rsp_halted;
   logic       rsp_moving_forward;
   logic [2:0] rsp_stick_state;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [9:0] csr_data;

   joystick_stepper_controller dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_axis_x         (req_axis_x),
      .req_axis_y         (req_axis_y),
      .req_button_pressed (req_button_pressed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coil_pattern   (rsp_coil_pattern),
      .rsp_led_pattern    (rsp_led_pattern),
      .rsp_speed_level    (rsp_speed_level),
      .rsp_halted         (rsp_halted),
      .rsp_moving_forward (rsp_moving_forward),
      .rsp_stick_state    (rsp_stick_state),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Predictor state: config copy plus the block's registers
   logic [9:0] center_q;
   logic [8:0] thresh_q;
   logic [2:0] stick_q;
   logic [1:0] speed_q;
   logic       fwd_q;
   logic       halt_q;
   logic [3:0] led_q;
   logic [2:0] phase_q;
   logic [1:0] wait_q;
   logic [3:0] coil_q;

   motor_status_type due_status[$];
   script_row_type   script[$];
   int               mismatches = 0;
   int               rsp_seen = 0;
   int               idle_cycles = 0;
   bit               tx_calm = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [9:0] clamp_axis(input int v);
      if (v < 0) return 10'd0;
      if (v > 1023) return 10'd1023;
      return v[9:0];
   endfunction

   function automatic void reset_model();
      center_q = 10'd512;
      thresh_q = 9'd200;
      stick_q  = CODE_START;
      speed_q  = SPEED_RESET;
      fwd_q    = 1'b0;
      halt_q   = 1'b0;
      led_q    = 4'h0;
      phase_q  = 3'd0;
      wait_q   = 2'd0;
      coil_q   = 4'h0;
   endfunction

   // Sort a joystick sample by dominant axis and deadzone
   function automatic logic [2:0] sort_sample(input logic [9:0] ax, ay, input logic btn);
      int dx, dy, mx, my, thr;
      dx  = int'(ax) - int'(center_q);
      dy  = int'(ay) - int'(center_q);
      mx  = (dx < 0) ? -dx : dx;
      my  = (dy < 0) ? -dy : dy;
      thr = int'(thresh_q);
      if (btn) return CODE_BTN;
      if (mx > my) begin
         if (mx >= thr) return (dx < 0) ? CODE_DOWN : CODE_UP;
      end else begin
         if (my >= thr) return (dy < 0) ? CODE_LEFT : CODE_RIGHT;
      end
      return CODE_NEUT;
   endfunction

   // Advance the predictor by one word and return the status it produces
   function automatic motor_status_type step_model(input logic mode, input logic [9:0] ax, ay,
                                                   input logic btn);
      logic [2:0] cls;
      logic [2:0] nxt;
      if (mode == MODE_TICK) begin
         if (!halt_q) begin
            if (wait_q != 2'd0) begin
               wait_q = wait_q - 2'd1;
            end else begin
               wait_q  = SPEED_MAX - speed_q;
               coil_q  = HALF_STEP_SEQ[phase_q*4 +: 4];
               phase_q = fwd_q ? phase_q + 3'd1 : phase_q - 3'd1;
            end
         end
      end else begin
         cls = sort_sample(ax, ay, btn);
         case (stick_q)
            CODE_BTN, CODE_UP, CODE_DOWN: begin
               nxt = (cls == stick_q) ? stick_q : CODE_NEUT;
            end
            CODE_NEUT, CODE_LEFT, CODE_RIGHT: begin
               nxt = cls;
               if (cls == CODE_UP && speed_q != SPEED_MAX) speed_q = speed_q + 2'd1;
               if (cls == CODE_DOWN && speed_q != SPEED_MIN) speed_q = speed_q - 2'd1;
            end
            default: begin
               nxt = CODE_RIGHT;
            end
         endcase
         stick_q = nxt;
         case (nxt)
            CODE_BTN: begin
               led_q  = IND_ALL;
               halt_q = 1'b1;
            end
            CODE_NEUT: begin
               led_q  = fwd_q ? IND_LEFT : IND_RIGHT;
               halt_q = 1'b0;
            end
            CODE_UP: begin
               led_q = led_q | IND_UP;
            end
            CODE_DOWN: begin
               led_q = led_q | IND_DOWN;
            end
            CODE_LEFT: begin
               led_q = IND_LEFT;
               fwd_q = 1'b1;
            end
            default: begin
               led_q = IND_RIGHT;
               fwd_q = 1'b0;
            end
         endcase
      end
      return '{coil: coil_q, led: led_q, speed: speed_q, halt: halt_q, fwd: fwd_q,
               state: stick_q};
   endfunction

   task automatic add_row(input logic mode, input int ax, ay, input logic btn, input bit known,
                          input logic [3:0] coil, led, input logic [1:0] spd,
                          input logic halt, fwd, input logic [2:0] st);
      script_row_type row;
      row.mode  = mode;
      row.ax    = ax[9:0];
      row.ay    = ay[9:0];
      row.btn   = btn;
      row.known = known;
      row.want  = '{coil: coil, led: led, speed: spd, halt: halt, fwd: fwd, state: st};
      script.push_back(row);
   endtask

   // Offer one word, hold it until taken, then queue its expected status
   task automatic send_word(input logic mode, input logic [9:0] ax, ay, input logic btn,
                            input bit known, input motor_status_type want);
      int gap;
      motor_status_type predicted;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_axis_x         <= ax;
      req_axis_y         <= ay;
      req_button_pressed <= btn;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = step_model(mode, ax, ay, btn);
      due_status.push_back(known ? want : predicted);
      @(negedge clock);
   endtask

   // Random word, shaped around the current center and deadzone
   task automatic draw_word(output logic mode, output logic [9:0] ax, ay, output logic btn);
      int kind, d, ctr, thr, sx, sy;
      logic [9:0] major, minor;
      mode = ($urandom_range(0, 99) < 45) ? MODE_TICK : MODE_STICK;
      btn  = ($urandom_range(0, 99) < 10);
      ctr  = int'(center_q);
      thr  = int'(thresh_q);
      sx   = $urandom_range(0, 1) ? 1 : -1;
      sy   = $urandom_range(0, 1) ? 1 : -1;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: begin
            major = 10'($urandom);
            minor = 10'($urandom);
         end
         2, 3: begin
            major = (sx > 0) ? 10'd1023 : 10'd0;
            minor = clamp_axis(ctr + int'($urandom_range(0, 40)) - 20);
         end
         4, 5: begin
            // right at the deadzone edge
            d     = thr + int'($urandom_range(0, 2)) - 1;
            major = clamp_axis(ctr + sx * d);
            minor = clamp_axis(ctr + int'($urandom_range(0, 10)) - 5);
         end
         6: begin
            // equal deflection on both axes
            d     = $urandom_range(0, 511);
            major = clamp_axis(ctr + sx * d);
            minor = clamp_axis(ctr + sy * d);
         end
         default: begin
            d     = $urandom_range(thr, 511);
            major = clamp_axis(ctr + sx * d);
            minor = clamp_axis(ctr + sy * int'($urandom_range(0, d / 2)));
         end
      endcase
      if ($urandom_range(0, 1)) begin
         ax = major;
         ay = minor;
      end else begin
         ax = minor;
         ay = major;
      end
   endtask

   // Write both registers and one ignored index, one per cycle
   task automatic program_csr(input logic [9:0] center_val, input logic [9:0] thresh_val);
      csr_we    <= 1'b1;
      csr_index <= CSR_CENTER;
      csr_data  <= center_val;
      @(negedge clock);
      csr_index <= CSR_THRESHOLD;
      csr_data  <= thresh_val;
      @(negedge clock);
      csr_index <= $urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI;
      csr_data  <= 10'($urandom);
      @(negedge clock);
      csr_we    <= 1'b0;
      center_q = center_val;
      thresh_q = thresh_val[8:0];
   endtask

   // Stimulus
   initial begin
      logic       mode, btn;
      logic [9:0] ax, ay;
      logic [9:0] centers[6];
      logic [9:0] threshes[6];
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_mode           = MODE_TICK;
      req_axis_x         = 10'd0;
      req_axis_y         = 10'd0;
      req_button_pressed = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_CENTER;
      csr_data           = 10'd0;
      reset_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      //       kind        x     y     btn known coil  led   spd   halt fwd state
      add_row(MODE_TICK,  1023, 1023, 0,  1,    4'h8, 4'h0, 2'd1, 0,   0,  CODE_START);
      add_row(MODE_STICK,  512,  512, 0,  1,    4'h8, 4'h8, 2'd1, 0,   0,  CODE_RIGHT);
      add_row(MODE_STICK, 1023,  512, 0,  1,    4'h8, 4'h9, 2'd2, 0,   0,  CODE_UP);
      add_row(MODE_STICK,    0,  512, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK,    0,  512, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK,  712,  512, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK,  712,  512, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK,  711,  512, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK,  711,  512, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK,  512,    0, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_TICK,     0,    0, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_TICK,     0, 1023, 1,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_TICK,  1023,    0, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK,    0,    0, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK, 1023, 1023, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK,    0,    0, 1,  1,    4'h9, 4'hF, 2'd2, 1,   0,  CODE_BTN);
      add_row(MODE_TICK,   512,  512, 0,  1,    4'h9, 4'hF, 2'd2, 1,   0,  CODE_BTN);
      add_row(MODE_STICK, 1023,  512, 1,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK,  512,  512, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK, 1023,  512, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK,  512,  512, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_STICK, 1023,  512, 0,  1,    4'h9, 4'h9, 2'd3, 0,   0,  CODE_UP);
      add_row(MODE_TICK,     0,    0, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_TICK,     0,    0, 0,  0,    0,    0,    0,    0,   0,  CODE_START);
      add_row(MODE_TICK,     0,    0, 0,  0,    0,    0,    0,    0,   0,  CODE_START);

      foreach (script[i])
         send_word(script[i].mode, script[i].ax, script[i].ay, script[i].btn,
                   script[i].known, script[i].want);

      // config settings for the random phases, extremes first
      centers[0] = 10'd0;    threshes[0] = 10'd0;
      centers[1] = 10'd1023; threshes[1] = 10'd511;
      centers[2] = 10'd512;  threshes[2] = 10'h3FF;
      centers[3] = 10'($urandom); threshes[3] = 10'($urandom);
      centers[4] = 10'd512;  threshes[4] = 10'd200;
      centers[5] = 10'($urandom); threshes[5] = 10'($urandom_range(0, 300));

      for (int p = 0; p < 6; p++) begin
         // settle before touching the registers
         req_valid <= 1'b0;
         while (due_status.size() != 0) @(negedge clock);
         repeat (4) @(negedge clock);
         program_csr(centers[p], threshes[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            draw_word(mode, ax, ay, btn);
            send_word(mode, ax, ay, btn, 1'b0, '0);
         end
      end

      // drain
      req_valid <= 1'b0;
      while (due_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && due_status.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Result side ready: random stalls, calm stretches, one long hold-off
   initial begin
      int  stall_left;
      int  cyc;
      bit  rx_calm;
      bit  held_off;
      stall_left = 0;
      cyc        = 0;
      rx_calm    = 1'b0;
      held_off   = 1'b0;
      rsp_ready  = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!held_off && rsp_seen >= 300) begin
            // long hold so the block fills and back-pressures the input
            held_off   = 1'b1;
            stall_left = HOLD_OFF_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap(1'b0);
            if (stall_left > 0) stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      motor_status_type got;
      motor_status_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = {rsp_coil_pattern, rsp_led_pattern, rsp_speed_level, rsp_halted,
                rsp_moving_forward, rsp_stick_state};
         rsp_seen++;
         if (due_status.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result word %0d with nothing expected: coil=%h led=%h", rsp_seen,
                        got.coil, got.led);
         end else begin
            want = due_status.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"word %0d mismatch: expected coil=%h led=%h spd=%0d halt=%b ",
                            "fwd=%b st=%0d, got coil=%h led=%h spd=%0d halt=%b fwd=%b st=%0d"},
                           rsp_seen, want.coil, want.led, want.speed, want.halt, want.fwd,
                           want.state, got.coil, got.led, got.speed, got.halt, got.fwd,
                           got.state);
            end
         end
      end
   end

   // Watchdog: too long with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
